/* src/ptm_pkg.sv */
`timescale 1ns / 1ps
package ptm_pkg;

  // fixed point constants
  localparam logic signed [19:0] HALF_Q15 = 20'sd16384;
  localparam logic signed [19:0] ONE_Q15  = 20'sd32768;

  // cordic datapath width
  localparam int CW = 34;

  // primitive selectors
  localparam logic [2:0] ACT_CONE   = 3'd0;
  localparam logic [2:0] ACT_CUBE   = 3'd1;
  localparam logic [2:0] ACT_CYL    = 3'd2;
  localparam logic [2:0] ACT_SPHERE = 3'd3;

  // register indexes
  localparam logic [2:0] CFG_REPEAT_U = 3'd0;
  localparam logic [2:0] CFG_REPEAT_V = 3'd1;
  localparam logic [2:0] CFG_TEX_W    = 3'd2;
  localparam logic [2:0] CFG_TEX_H    = 3'd3;
  localparam logic [2:0] CFG_EDGE_TOL = 3'd4;

  // how u and v are formed at the end of the pipe
  localparam logic [1:0] MODE_FIXED  = 2'd0;
  localparam logic [1:0] MODE_SIDE   = 2'd1;
  localparam logic [1:0] MODE_SPHERE = 2'd2;

  // atan(2^-i) as binary angles, pi = 2^31
  localparam logic [31:0] ATAN_BAM [24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // data carried alongside the arithmetic chains
  typedef struct packed {
    logic [1:0]         mode;
    logic signed [17:0] u_cap;
    logic signed [17:0] v_cap;
    logic signed [15:0] px;
    logic signed [15:0] pz;
    logic signed [16:0] a;
    logic               lat_zero;
    logic               side_zero;
  } side_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } cord_t;

  // closeness test within tolerance
  function automatic logic near_q15(input logic signed [19:0] a,
                                    input logic signed [19:0] b,
                                    input logic [9:0] tol);
    logic signed [20:0] d;
    d = 21'(a) - 21'(b);
    if (d < 0) d = -d;
    return d <= $signed({11'd0, tol});
  endfunction

  // clamp to [0, 1] in q1.15
  function automatic logic [15:0] clamp_q15(input logic signed [19:0] v);
    if (v < 0) return 16'd0;
    if (v > ONE_Q15) return 16'd32768;
    return v[15:0];
  endfunction

  // scale by 2^14 and fold the left half plane onto the right
  function automatic cord_t cordic_prep(input logic signed [16:0] y,
                                        input logic signed [16:0] x);
    cord_t c;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    xs = {{(CW-17){x[16]}}, x} <<< 14;
    ys = {{(CW-17){y[16]}}, y} <<< 14;
    c.x = xs;
    c.y = ys;
    c.z = '0;
    if (xs < 0) begin
      if (ys >= 0) begin
        c.x = ys;
        c.y = -xs;
        c.z = CW'(64'sh40000000);
      end else begin
        c.x = -ys;
        c.y = xs;
        c.z = -CW'(64'sh40000000);
      end
    end
    return c;
  endfunction

endpackage

/* src/ptm_in_if.sv */
`timescale 1ns / 1ps
interface ptm_in_if;
  logic              valid;
  logic              ready;
  logic [2:0]        action;
  logic signed [15:0] point_x;
  logic signed [15:0] point_y;
  logic signed [15:0] point_z;

  modport source (output valid, action, point_x, point_y, point_z, input ready);
  modport sink   (input valid, action, point_x, point_y, point_z, output ready);
endinterface

/* src/ptm_out_if.sv */
`timescale 1ns / 1ps
interface ptm_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] tex_u;
  logic [15:0] tex_v;
  logic [11:0] texel_s;
  logic [11:0] texel_t;

  modport source (output valid, tex_u, tex_v, texel_s, texel_t, input ready);
  modport sink   (input valid, tex_u, tex_v, texel_s, texel_t, output ready);
endinterface

/* src/primitive_uv_texel_mapper_core.sv */
`timescale 1ns / 1ps
// channel  | dir | handshake      | payload
// in_ch    | in  | valid / ready  | action, point_x, point_y, point_z
// out_ch   | out | valid / ready  | tex_u, tex_v, texel_s, texel_t
// cfg      | in  | cfg_we         | cfg_index, cfg_wdata
//
// One request per cycle while the output is not held; a request passes the
// input registers, the sixteen square root cells and the cordic cell chain.
// Synchronous active low reset clears valid bits and loads the configuration defaults.
// The whole pipe advances together; it holds while the output request waits.
module primitive_uv_texel_mapper_core
  import ptm_pkg::*;
#(
  parameter int CORDIC_STAGES = 16,
  parameter int MAX_TEX_SIZE  = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  ptm_in_if.sink      in_ch,
  ptm_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int DW = $clog2(MAX_TEX_SIZE + 1);
  localparam int SQ = 16;
  localparam int PS = SQ + 1;
  localparam int P  = PS + CORDIC_STAGES;

  // configuration registers
  logic [15:0] rep_u_r, rep_v_r;
  logic [12:0] tex_w_r, tex_h_r;
  logic [9:0]  tol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rep_u_r <= 16'd256;
      rep_v_r <= 16'd256;
      tex_w_r <= 13'd256;
      tex_h_r <= 13'd256;
      tol_r   <= 10'd4;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_REPEAT_U: rep_u_r <= cfg_wdata;
        CFG_REPEAT_V: rep_v_r <= cfg_wdata;
        CFG_TEX_W:    tex_w_r <= cfg_wdata[12:0];
        CFG_TEX_H:    tex_h_r <= cfg_wdata[12:0];
        CFG_EDGE_TOL: tol_r   <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

  // saturated texture size
  function automatic logic [DW-1:0] sat_dim(input logic [12:0] dim);
    if (dim == 13'd0) return DW'(1);
    if ({3'd0, dim} > 16'(MAX_TEX_SIZE)) return DW'(MAX_TEX_SIZE);
    return DW'(dim);
  endfunction

  logic [DW-1:0] dw_u, dh_u;
  assign dw_u = sat_dim(tex_w_r);
  assign dh_u = sat_dim(tex_h_r);

  // global advance
  logic en;
  logic vo_r;
  assign en          = !vo_r || out_ch.ready;
  assign in_ch.ready = en;

  // front decode
  logic signed [19:0] px, py, pz;
  logic signed [17:0] a2;
  logic signed [16:0] a_c;
  logic [15:0]        a_abs;
  logic [31:0]        a_sq;
  logic [30:0]        n0;
  side_t              sb0;

  always_comb begin
    px = 20'(in_ch.point_x);
    py = 20'(in_ch.point_y);
    pz = 20'(in_ch.point_z);
    a2 = 18'(in_ch.point_y) <<< 1;
    if (a2 > 18'sd32768) a_c = 17'sd32768;
    else if (a2 < -18'sd32768) a_c = -17'sd32768;
    else a_c = a2[16:0];
    a_abs = a_c < 0 ? 16'(-a_c) : 16'(a_c);
    a_sq  = {16'd0, a_abs} * {16'd0, a_abs};
    n0    = 31'(32'h40000000 - a_sq);

    sb0           = '0;
    sb0.px        = in_ch.point_x;
    sb0.pz        = in_ch.point_z;
    sb0.a         = a_c;
    sb0.mode      = MODE_FIXED;
    case (in_ch.action)
      ACT_CUBE: begin
        if (near_q15(px, HALF_Q15, tol_r)) begin
          sb0.u_cap = 18'(HALF_Q15 - pz);
          sb0.v_cap = 18'(HALF_Q15 - py);
        end else if (near_q15(px, -HALF_Q15, tol_r)) begin
          sb0.u_cap = 18'(pz + HALF_Q15);
          sb0.v_cap = 18'(HALF_Q15 - py);
        end else if (near_q15(py, HALF_Q15, tol_r)) begin
          sb0.u_cap = 18'(px + HALF_Q15);
          sb0.v_cap = 18'(pz + HALF_Q15);
        end else if (near_q15(py, -HALF_Q15, tol_r)) begin
          sb0.u_cap = 18'(px + HALF_Q15);
          sb0.v_cap = 18'(HALF_Q15 - pz);
        end else if (near_q15(pz, HALF_Q15, tol_r)) begin
          sb0.u_cap = 18'(px + HALF_Q15);
          sb0.v_cap = 18'(HALF_Q15 - py);
        end else begin
          sb0.u_cap = 18'(HALF_Q15 - px);
          sb0.v_cap = 18'(HALF_Q15 - py);
        end
      end
      ACT_CYL: begin
        if (near_q15(py, HALF_Q15, tol_r)) begin
          sb0.u_cap = 18'(px + HALF_Q15);
          sb0.v_cap = 18'(pz + HALF_Q15);
        end else if (near_q15(py, -HALF_Q15, tol_r)) begin
          sb0.u_cap = 18'(px + HALF_Q15);
          sb0.v_cap = 18'(HALF_Q15 - pz);
        end else begin
          sb0.mode  = MODE_SIDE;
          sb0.v_cap = 18'(HALF_Q15 - py);
        end
      end
      ACT_CONE: begin
        if (near_q15(py, -HALF_Q15, tol_r)) begin
          sb0.u_cap = 18'(px + HALF_Q15);
          sb0.v_cap = 18'(HALF_Q15 - pz);
        end else begin
          sb0.mode  = MODE_SIDE;
          sb0.v_cap = 18'(HALF_Q15 - py);
        end
      end
      ACT_SPHERE: sb0.mode = MODE_SPHERE;
      default: ;
    endcase
  end

  // sideband shift line and valid bits
  logic  vld_r [0:P];
  side_t sb_r  [0:P];
  logic [30:0] n0_r;
  logic [30:0] sn [0:SQ];
  logic [30:0] sq_r [0:SQ];

  logic [15:0]      c_sq;
  cord_t            lat_p, side_p;
  side_t            sb_ps;
  assign c_sq   = sq_r[SQ][15:0];
  assign lat_p  = cordic_prep(sb_r[SQ].a, {1'b0, c_sq});
  assign side_p = cordic_prep(17'(sb_r[SQ].pz), 17'(sb_r[SQ].px));

  // zero-vector flags join the sideband as the cordic starts
  always_comb begin
    sb_ps           = sb_r[SQ];
    sb_ps.lat_zero  = (sb_r[SQ].a == 17'sd0) && (c_sq == 16'd0);
    sb_ps.side_zero = (sb_r[SQ].px == 16'sd0) && (sb_r[SQ].pz == 16'sd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= P; k++) vld_r[k] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_ch.valid;
      for (int k = 1; k <= P; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb_r[0] <= sb0;
      n0_r    <= n0;
      for (int k = 1; k <= P; k++) sb_r[k] <= (k == PS) ? sb_ps : sb_r[k-1];
    end
  end

  // square root cell chain
  assign sn[0]   = n0_r;
  assign sq_r[0] = '0;

  for (genvar k = 0; k < SQ; k++) begin : g_sqrt
    ptm_sqrt_cell #(.BIT_POS(30 - 2 * k)) u_cell (
      .clk (clk),
      .en  (en),
      .n_i (sn[k]),
      .r_i (sq_r[k]),
      .n_o (sn[k+1]),
      .r_o (sq_r[k+1])
    );
  end

  // cordic start registers
  cord_t lat_c  [0:CORDIC_STAGES];
  cord_t side_c [0:CORDIC_STAGES];
  cord_t lat_p_r, side_p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      lat_p_r  <= lat_p;
      side_p_r <= side_p;
    end
  end

  assign lat_c[0]  = lat_p_r;
  assign side_c[0] = side_p_r;

  // cordic cell chain, latitude and side angle side by side
  for (genvar j = 0; j < CORDIC_STAGES; j++) begin : g_cordic
    ptm_cordic_cell #(.STAGE(j)) u_lat (
      .clk (clk),
      .en  (en),
      .c_i (lat_c[j]),
      .c_o (lat_c[j+1])
    );
    ptm_cordic_cell #(.STAGE(j)) u_side (
      .clk (clk),
      .en  (en),
      .c_i (side_c[j]),
      .c_o (side_c[j+1])
    );
  end

  // angle to u and v
  side_t              sbp;
  logic signed [35:0] th, lat;
  logic signed [35:0] th_neg, th_pos, lat_rnd;
  logic signed [19:0] side_u, v_sph, u_sel, v_sel;
  logic               vf_r;
  logic [15:0]        u_f_r, v_f_r;

  always_comb begin
    sbp     = sb_r[P];
    th      = sbp.side_zero ? 36'sd0 : 36'(side_c[CORDIC_STAGES].z);
    lat     = sbp.lat_zero ? 36'sd0 : 36'(lat_c[CORDIC_STAGES].z);
    th_neg  = (36'sd65536 - th) >>> 17;
    th_pos  = (th + 36'sd65536) >>> 17;
    side_u  = (th < 0) ? 20'(th_neg) : 20'(ONE_Q15 - 20'(th_pos));
    lat_rnd = (lat + 36'sd32768) >>> 16;
    v_sph   = 20'(HALF_Q15 - 20'(lat_rnd));
    u_sel   = 20'(sbp.u_cap);
    v_sel   = 20'(sbp.v_cap);
    case (sbp.mode)
      MODE_SIDE: u_sel = side_u;
      MODE_SPHERE: begin
        v_sel = v_sph;
        if (near_q15(v_sph, ONE_Q15, tol_r) || near_q15(v_sph, 20'sd0, tol_r)) begin
          u_sel = HALF_Q15;
        end else begin
          u_sel = side_u;
        end
      end
      default: ;
    endcase
  end

  // multiply stages
  logic        vm_r;
  logic [15:0] u_m_r, v_m_r;
  logic [22:0] pu_r, pv_r;
  logic [31:0] pu, pv;
  logic [37:0] ps, pt;
  logic [15:0] u_o_r, v_o_r;
  logic [11:0] s_o_r, t_o_r;

  assign pu = {16'd0, u_f_r} * {16'd0, rep_u_r};
  assign pv = {16'd0, v_f_r} * {16'd0, rep_v_r};
  assign ps = 38'(pu_r) * 38'(dw_u);
  assign pt = 38'(pv_r) * 38'(dh_u);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= 1'b0;
      vm_r <= 1'b0;
      vo_r <= 1'b0;
    end else if (en) begin
      vf_r <= vld_r[P];
      vm_r <= vf_r;
      vo_r <= vm_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u_f_r <= clamp_q15(u_sel);
      v_f_r <= clamp_q15(v_sel);
      u_m_r <= u_f_r;
      v_m_r <= v_f_r;
      pu_r  <= pu[22:0];
      pv_r  <= pv[22:0];
      u_o_r <= u_m_r;
      v_o_r <= v_m_r;
      s_o_r <= ps[34:23];
      t_o_r <= pt[34:23];
    end
  end

  assign out_ch.valid   = vo_r;
  assign out_ch.tex_u   = u_o_r;
  assign out_ch.tex_v   = v_o_r;
  assign out_ch.texel_s = s_o_r;
  assign out_ch.texel_t = t_o_r;

  // checks
  a_accept_enters : assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> vld_r[0])
    else $error("accepted request did not enter the pipe");

  a_u_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.tex_u <= 16'd32768) && (out_ch.tex_v <= 16'd32768))
    else $error("texture coordinate above one");

  a_s_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !cfg_we |->
      (MAX_TEX_SIZE > 4096) || (16'(out_ch.texel_s) < 16'(dw_u)))
    else $error("texel column beyond texture width");

  a_t_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !cfg_we |->
      (MAX_TEX_SIZE > 4096) || (16'(out_ch.texel_t) < 16'(dh_u)))
    else $error("texel row beyond texture height");

endmodule

/* src/ptm_sqrt_cell.sv */
`timescale 1ns / 1ps
module ptm_sqrt_cell #(
  parameter int BIT_POS = 30
) (
  input  logic        clk,
  input  logic        en,
  input  logic [30:0] n_i,
  input  logic [30:0] r_i,
  output logic [30:0] n_o,
  output logic [30:0] r_o
);

  localparam logic [31:0] BIT = 32'd1 << BIT_POS;

  logic [31:0] trial;
  logic [30:0] n_nxt;
  logic [30:0] r_nxt;
  logic [30:0] n_r;
  logic [30:0] r_r;

  // one result bit per cell
  always_comb begin
    trial = {1'b0, r_i} + BIT;
    if ({1'b0, n_i} >= trial) begin
      n_nxt = n_i - trial[30:0];
      r_nxt = (r_i >> 1) + BIT[30:0];
    end else begin
      n_nxt = n_i;
      r_nxt = r_i >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_r <= n_nxt;
      r_r <= r_nxt;
    end
  end

  assign n_o = n_r;
  assign r_o = r_r;

endmodule

/* src/ptm_cordic_cell.sv */
`timescale 1ns / 1ps
module ptm_cordic_cell
  import ptm_pkg::*;
#(
  parameter int STAGE = 0
) (
  input  logic  clk,
  input  logic  en,
  input  cord_t c_i,
  output cord_t c_o
);

  localparam logic signed [CW-1:0] ANG = {{(CW-32){1'b0}}, ATAN_BAM[STAGE]};

  cord_t c_nxt;
  cord_t c_r;

  // one vectoring micro-rotation
  always_comb begin
    if (c_i.y > 0) begin
      c_nxt.x = c_i.x + (c_i.y >>> STAGE);
      c_nxt.y = c_i.y - (c_i.x >>> STAGE);
      c_nxt.z = c_i.z + ANG;
    end else begin
      c_nxt.x = c_i.x - (c_i.y >>> STAGE);
      c_nxt.y = c_i.y + (c_i.x >>> STAGE);
      c_nxt.z = c_i.z - ANG;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_r <= c_nxt;
    end
  end

  assign c_o = c_r;

endmodule
